// ===== hw/rtl/catmull_rom_spline_eval_top_defines.svh =====
// assertion macros for the catmull-rom spline evaluator
// used by catmull_rom_spline_eval_top; expects clk_i and rst_ni in scope
`ifndef CATMULL_ROM_SPLINE_EVAL_TOP_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVAL_TOP_DEFINES_SVH

`ifndef SYNTH

// condition that must hold at every edge out of reset
`define CSEV_ASSERT_ALWAYS(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("csev: invariant violated");

// consequence that must hold in the cycle after the trigger
`define CSEV_ASSERT_NEXT(name, trig, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("csev: next-cycle check violated");

`else

`define CSEV_ASSERT_ALWAYS(name, cond)
`define CSEV_ASSERT_NEXT(name, trig, cons)

`endif

`endif

// ===== hw/rtl/csev_pkg.sv =====
// shared types and constants of the catmull-rom spline evaluator
// no dependencies; imported by every module of the block
package csev_pkg;

  // sizes of the request and result fields
  localparam int unsigned MaxKnots = 8;
  localparam int unsigned IdxW     = $clog2(MaxKnots);
  localparam int unsigned PosW     = 18;
  localparam int unsigned CountW   = 4;
  localparam int unsigned KnotW    = 32;

  // datapath sizes: fraction 0..1.0 in q1.16, coefficients and horner terms
  localparam int unsigned FracW    = 17;
  localparam int unsigned CoefW    = 38;
  localparam int unsigned ProdW    = CoefW + FracW + 1;
  localparam int unsigned RndShift = 16;

  localparam logic [FracW-1:0]        FracOne   = FracW'(65536);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(32768);

  typedef struct packed {
    logic signed [PosW-1:0]  position;
    logic [CountW-1:0]       knot_count;
    logic signed [KnotW-1:0] knot_a;
    logic signed [KnotW-1:0] knot_b;
    logic signed [KnotW-1:0] knot_c;
    logic signed [KnotW-1:0] knot_d;
    logic signed [KnotW-1:0] knot_e;
    logic signed [KnotW-1:0] knot_f;
    logic signed [KnotW-1:0] knot_g;
    logic signed [KnotW-1:0] knot_h;
  } csev_in_t;

  typedef struct packed {
    logic signed [KnotW-1:0] spline_value;
    logic                    invalid_count;
  } csev_out_t;

  // per-item values that ride along the horner stages
  typedef struct packed {
    logic [FracW-1:0]        frac;
    logic signed [CoefW-1:0] coef_b;
    logic signed [CoefW-1:0] coef_c;
    logic signed [KnotW-1:0] coef_d;
    logic                    invalid_count;
  } csev_side_t;

endpackage

// ===== hw/rtl/csev_span.sv =====
// span selection and catmull-rom coefficient stages (two register stages)
// depends on csev_pkg
module csev_span (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  csev_pkg::csev_in_t                   in_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [csev_pkg::CoefW-1:0]    coef_a_o,
  output csev_pkg::csev_side_t                 side_o
);
  import csev_pkg::*;

  logic signed [KnotW-1:0] knots [MaxKnots];
  logic [FracW-1:0]        pos_clamp;
  logic [CountW-1:0]       cnt_eff;
  logic [IdxW-1:0]         nspans;
  logic [FracW+IdxW-1:0]   scaled;
  logic [IdxW-1:0]         span_raw;
  logic                    capped;
  logic [IdxW-1:0]         span;

  logic                    v1_q, v2_q;
  logic                    rdy1, rdy2;
  logic signed [KnotW-1:0] k_q [4];
  logic signed [KnotW-1:0] k_d [4];
  logic [FracW-1:0]        f_q;
  logic                    inv_q;

  logic signed [CoefW-1:0] ke [4];
  logic signed [CoefW-1:0] a_d, a_q;
  csev_side_t              side_d, side_q;

  // knot slots as an array
  assign knots[0] = in_i.knot_a;
  assign knots[1] = in_i.knot_b;
  assign knots[2] = in_i.knot_c;
  assign knots[3] = in_i.knot_d;
  assign knots[4] = in_i.knot_e;
  assign knots[5] = in_i.knot_f;
  assign knots[6] = in_i.knot_g;
  assign knots[7] = in_i.knot_h;

  // clamp position, scale by span count, split into span and fraction
  always_comb begin
    if (in_i.position[PosW-1]) begin
      pos_clamp = '0;
    end else if (in_i.position > PosW'(65536)) begin
      pos_clamp = FracOne;
    end else begin
      pos_clamp = in_i.position[FracW-1:0];
    end
    cnt_eff  = (in_i.knot_count > CountW'(MaxKnots)) ? CountW'(MaxKnots) : in_i.knot_count;
    nspans   = IdxW'(cnt_eff - CountW'(3));
    scaled   = (FracW+IdxW)'(pos_clamp) * (FracW+IdxW)'(nspans);
    // scaled stays below 2^19, so the span fits in the low index bits
    span_raw = scaled[RndShift+IdxW-1:RndShift];
    capped   = (span_raw >= nspans);
    span     = capped ? IdxW'(nspans - IdxW'(1)) : span_raw;
    for (int i = 0; i < 4; i++) begin
      k_d[i] = knots[IdxW'(span + IdxW'(i))];
    end
  end

  // handshake chain
  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  // stage 1: span knots and local fraction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (rdy1) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      k_q   <= k_d;
      f_q   <= {capped, scaled[RndShift-1:0]};
      inv_q <= (in_i.knot_count < CountW'(4));
    end
  end

  // stage 2: doubled catmull-rom coefficients
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ke[i] = CoefW'(k_q[i]);
    end
    a_d = ke[3] - ke[0] + CoefW'(3) * (ke[1] - ke[2]);
    side_d.coef_b = CoefW'(2) * ke[0] - CoefW'(5) * ke[1] + CoefW'(4) * ke[2] - ke[3];
    side_d.coef_c = ke[2] - ke[0];
    side_d.coef_d = k_q[1];
    side_d.frac   = f_q;
    side_d.invalid_count = inv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (rdy2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      a_q    <= a_d;
      side_q <= side_d;
    end
  end

  assign valid_o  = v2_q;
  assign coef_a_o = a_q;
  assign side_o   = side_q;

endmodule

// ===== hw/rtl/csev_horner.sv =====
// one horner step: multiply by the fraction, then round and add (two stages)
// depends on csev_pkg
module csev_horner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [csev_pkg::CoefW-1:0] term_i,
  input  logic signed [csev_pkg::CoefW-1:0] addend_i,
  input  csev_pkg::csev_side_t              side_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [csev_pkg::CoefW-1:0] term_o,
  output csev_pkg::csev_side_t              side_o
);
  import csev_pkg::*;

  logic                    vm_q, vr_q;
  logic                    rdy_m, rdy_r;
  logic signed [FracW:0]   frac_s;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic signed [CoefW-1:0] add_q;
  csev_side_t              side_m_q, side_r_q;
  logic signed [ProdW-1:0] rsum;
  logic signed [CoefW-1:0] term_d, term_q;

  // handshake chain
  assign rdy_r   = !vr_q || ready_i;
  assign rdy_m   = !vm_q || rdy_r;
  assign ready_o = rdy_m;

  // multiply stage
  assign frac_s = $signed({1'b0, side_i.frac});
  assign prod_d = term_i * frac_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (rdy_m) begin
      vm_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_m && valid_i) begin
      prod_q   <= prod_d;
      add_q    <= addend_i;
      side_m_q <= side_i;
    end
  end

  // round to nearest at bit 16 and add the next coefficient
  assign rsum   = prod_q + RoundHalf;
  assign term_d = $signed(rsum[CoefW+RndShift-1:RndShift]) + add_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (rdy_r) begin
      vr_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_r && vm_q) begin
      term_q   <= term_d;
      side_r_q <= side_m_q;
    end
  end

  assign valid_o = vr_q;
  assign term_o  = term_q;
  assign side_o  = side_r_q;

endmodule

// ===== hw/rtl/catmull_rom_spline_eval_top.sv =====
// top level of the catmull-rom spline evaluator: span stages, three horner steps,
// final halving, saturation and output register; depends on csev_pkg, csev_span,
// csev_horner and catmull_rom_spline_eval_top_defines.svh
//
//   channel   signals                           direction
//   request   in_valid_i / in_ready_o / in_i    into the block
//   result    out_valid_o / out_ready_i / out_o out of the block
//
// one request per cycle sustained while results are taken; each result passes through
// 2 span/coefficient stages, 3 horner steps of 2 stages each and 1 output stage
// every stage has a valid bit and loads when empty or when its successor moves,
// so a stalled result holds the whole pipeline without loss or duplication
// reset clears only the valid bits; the block takes requests right after reset
module catmull_rom_spline_eval_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  csev_pkg::csev_in_t  in_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output csev_pkg::csev_out_t out_o
);
  import csev_pkg::*;
  `include "catmull_rom_spline_eval_top_defines.svh"

  logic                    sp_valid, sp_ready;
  logic signed [CoefW-1:0] sp_a;
  csev_side_t              sp_side;

  logic                    h1_valid, h1_ready;
  logic signed [CoefW-1:0] h1_t;
  csev_side_t              h1_side;

  logic                    h2_valid, h2_ready;
  logic signed [CoefW-1:0] h2_t;
  csev_side_t              h2_side;

  logic                    h3_valid, h3_ready;
  logic signed [CoefW-1:0] h3_t;
  csev_side_t              h3_side;

  logic                    out_valid_q;
  csev_out_t               out_d, out_q;
  logic signed [CoefW-1:0] t_inc, t_half;
  logic signed [CoefW:0]   sum_r;

  // span select and coefficients
  csev_span u_span (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .in_i     (in_i),
    .valid_o  (sp_valid),
    .ready_i  (sp_ready),
    .coef_a_o (sp_a),
    .side_o   (sp_side)
  );

  // t = r(a*f) + b
  csev_horner u_horner_b (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sp_valid),
    .ready_o  (sp_ready),
    .term_i   (sp_a),
    .addend_i (sp_side.coef_b),
    .side_i   (sp_side),
    .valid_o  (h1_valid),
    .ready_i  (h1_ready),
    .term_o   (h1_t),
    .side_o   (h1_side)
  );

  // t = r(t*f) + c
  csev_horner u_horner_c (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (h1_valid),
    .ready_o  (h1_ready),
    .term_i   (h1_t),
    .addend_i (h1_side.coef_c),
    .side_i   (h1_side),
    .valid_o  (h2_valid),
    .ready_i  (h2_ready),
    .term_o   (h2_t),
    .side_o   (h2_side)
  );

  // t = r(t*f)
  csev_horner u_horner_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (h2_valid),
    .ready_o  (h2_ready),
    .term_i   (h2_t),
    .addend_i ('0),
    .side_i   (h2_side),
    .valid_o  (h3_valid),
    .ready_i  (h3_ready),
    .term_o   (h3_t),
    .side_o   (h3_side)
  );

  // halve with rounding, add the span's second knot, saturate; an invalid count gives zero
  always_comb begin
    t_inc  = h3_t + CoefW'(1);
    t_half = t_inc >>> 1;
    sum_r  = (CoefW+1)'(t_half) + (CoefW+1)'(h3_side.coef_d);
    if (h3_side.invalid_count) begin
      out_d.spline_value = '0;
    end else if (sum_r > (CoefW+1)'(2147483647)) begin
      out_d.spline_value = KnotW'(2147483647);
    end else if (sum_r < -(CoefW+1)'(64'sd2147483648)) begin
      out_d.spline_value = {1'b1, {(KnotW-1){1'b0}}};
    end else begin
      out_d.spline_value = sum_r[KnotW-1:0];
    end
    out_d.invalid_count = h3_side.invalid_count;
  end

  // output register
  assign h3_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (h3_ready) begin
      out_valid_q <= h3_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (h3_ready && h3_valid) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // an invalid knot count always yields a zero value
  `CSEV_ASSERT_ALWAYS(a_invalid_zero, !(out_valid_o && out_o.invalid_count) || (out_o.spline_value == '0))
  // the pipeline only refuses requests when a finished result is held back
  `CSEV_ASSERT_ALWAYS(a_stall_cause, in_ready_o || (out_valid_o && !out_ready_i))
  // a finished item reaching a free output stage is presented next cycle
  `CSEV_ASSERT_NEXT(a_out_load, h3_valid && h3_ready, out_valid_o)

endmodule
